@@ design/yda_pkg.sv @@
// Shared constants and types for the yawn detector area/median block.
// Used by the front accumulator, the frame queue, the back end and the checker.
// No dependencies.
package yda_pkg;

  // Field widths of the ports.
  localparam int CoordW = 16;
  localparam int ScaleW = 16;
  localparam int AreaW  = 24;
  localparam int CountW = 16;

  // Shoelace sum width and the width of one cross product.
  localparam int SumW  = 40;
  localparam int ProdW = 2 * CoordW;

  // Median window.
  localparam int WindowSize = 5;
  localparam int WinIdxW    = $clog2(WindowSize);
  localparam int FramesW    = $clog2(WindowSize + 1);
  localparam int MedianIdx  = WindowSize / 2;

  // Queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Divider: one quotient bit per cycle.
  localparam int DivCntW = $clog2(AreaW);

  // Reset value of the threshold register (250.0 in Q20.4).
  localparam logic [AreaW-1:0] ThresholdReset = AreaW'(4000);

  // One finished frame polygon handed from the front to the back.
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [ScaleW-1:0] scale;
  } frame_t;

  // Fill status of the frame queue.
  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } qstat_t;

endpackage

@@ design/yda_front.sv @@
// Front end: one vertex per cycle unless stalled; keeps the running shoelace sum.
// Pushes the closed sum and the frame scale into the frame queue on the last vertex.
// Depends on yda_pkg.
module yda_front
  import yda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] vertex_x_i,
  input  logic [CoordW-1:0] vertex_y_i,
  input  logic [ScaleW-1:0] frame_scale_i,
  input  logic              last_vertex_i,
  input  qstat_t            qstat_i,
  output logic              push_o,
  output frame_t            push_word_o
);

  logic                accept;
  logic                mid_q, mid_d;
  logic [CoordW-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [CoordW-1:0]   first_x_eff, first_y_eff;
  logic [QCntW:0]      pending;

  // Product stage registers.
  logic                s1_valid_q, s1_start_q, s1_last_q;
  logic [ScaleW-1:0]   s1_scale_q;
  logic [ProdW-1:0]    p1_q, p2_q, c1_q, c2_q;

  // Accumulator stage.
  logic [SumW-1:0]     sum_q, sum_d, edge_term, close_term, base;

  // Hold off when the queue could not take the frame that is still in flight.
  assign pending    = {1'b0, qstat_i.count} + {{QCntW{1'b0}}, (s1_valid_q & s1_last_q)};
  assign in_stall_o = (pending >= (QCntW + 1)'(QueueDepth));
  assign accept     = in_valid_i & ~in_stall_o;

  // On the first vertex of a polygon the closing edge is against the vertex itself.
  assign first_x_eff = mid_q ? first_x_q : vertex_x_i;
  assign first_y_eff = mid_q ? first_y_q : vertex_y_i;
  assign mid_d       = ~last_vertex_i;

  // Vertex bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (accept) begin
      mid_q <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      if (!mid_q) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
      end
    end
  end

  // Cross-product terms, registered before they are summed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_start_q <= ~mid_q;
      s1_last_q  <= last_vertex_i;
      s1_scale_q <= frame_scale_i;
      p1_q       <= prev_x_q * vertex_y_i;
      p2_q       <= vertex_x_i * prev_y_q;
      c1_q       <= vertex_x_i * first_y_eff;
      c2_q       <= first_x_eff * vertex_y_i;
    end
  end

  // Running sum, modulo 2^40; the closing edge is added on the last vertex.
  always_comb begin
    base       = s1_start_q ? '0 : sum_q;
    edge_term  = s1_start_q ? '0 : ({{(SumW-ProdW){1'b0}}, p1_q} - {{(SumW-ProdW){1'b0}}, p2_q});
    close_term = s1_last_q ? ({{(SumW-ProdW){1'b0}}, c1_q} - {{(SumW-ProdW){1'b0}}, c2_q}) : '0;
    sum_d      = base + edge_term + close_term;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign push_o            = s1_valid_q & s1_last_q;
  assign push_word_o.sum   = sum_d;
  assign push_word_o.scale = s1_scale_q;

endmodule

@@ design/yda_queue.sv @@
// Short queue of finished frames between the front and the back end.
// Registered entries, one push and one pop per cycle.
// Depends on yda_pkg.
module yda_queue
  import yda_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_word_i,
  input  logic   pop_i,
  output frame_t head_o,
  output qstat_t qstat_o
);

  frame_t           entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign head_o        = entry_q[rd_ptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.count = count_q;

endmodule

@@ design/yda_back.sv @@
// Back end: normalises each frame's area, keeps the median window and the yawn count.
// Holds the threshold register and the output word register.
// Depends on yda_pkg.
module yda_back
  import yda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qstat_t            qstat_i,
  input  frame_t            head_i,
  output logic              pop_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [AreaW-1:0]  cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AreaW-1:0]  normalized_area_o,
  output logic [AreaW-1:0]  median_area_o,
  output logic              window_ready_o,
  output logic              yawning_o,
  output logic [CountW-1:0] yawn_total_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMag  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StWin  = 3'd3;
  localparam logic [2:0] StMed  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  localparam int DvdW = SumW + 3;
  localparam int HiW  = DvdW - AreaW;
  localparam int RankW = (WinIdxW > 0) ? WinIdxW : 1;

  logic [2:0]          state_q, state_d;
  logic [AreaW-1:0]    threshold_q;

  logic [SumW-1:0]     sum_q;
  logic [ScaleW-1:0]   scale_q;
  logic [SumW-1:0]     mag;
  logic [DvdW-1:0]     dividend;
  logic [HiW-1:0]      dvd_hi;
  logic                sat;

  logic [ScaleW-1:0]   rem_q;
  logic [AreaW-1:0]    quot_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [ScaleW:0]     trial, trial_diff;
  logic                trial_ge;

  logic [AreaW-1:0]    win_q [WindowSize];
  logic [FramesW-1:0]  frames_q;
  logic                ready_q;
  logic [WinIdxW-1:0]  med_k_q;
  logic [AreaW-1:0]    cand;
  logic [RankW-1:0]    rank;
  logic [AreaW-1:0]    median_q;

  logic                trigger_q, trigger_d;
  logic [CountW-1:0]   yawns_q, yawns_d;
  logic                slot_free;

  logic                out_valid_q;
  logic [AreaW-1:0]    out_norm_q, out_median_q;
  logic                out_ready_q, out_yawning_q;
  logic [CountW-1:0]   out_total_q;

  // Threshold register, writable at any time the port is used.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  // Absolute doubled area, times eight, and the saturation test.
  always_comb begin
    mag      = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
    dividend = {mag, 3'b000};
    dvd_hi   = dividend[DvdW-1:AreaW];
    sat      = (dvd_hi >= {{(HiW-ScaleW){1'b0}}, scale_q});
  end

  // One restoring division step.
  always_comb begin
    trial      = {rem_q, quot_q[AreaW-1]};
    trial_diff = trial - {1'b0, scale_q};
    trial_ge   = (trial >= {1'b0, scale_q});
  end

  // Rank of the candidate entry; ties are broken by position.
  always_comb begin
    cand = win_q[med_k_q];
    rank = '0;
    for (int j = 0; j < WindowSize; j++) begin
      if ((win_q[j] < cand) ||
          ((WinIdxW'(j) < med_k_q) && (win_q[j] == cand))) begin
        rank = rank + RankW'(1);
      end
    end
  end

  // Trigger and yawn count after this frame.
  always_comb begin
    trigger_d = trigger_q;
    yawns_d   = yawns_q;
    if (ready_q) begin
      if (median_q > threshold_q) begin
        trigger_d = 1'b1;
      end else if (trigger_q) begin
        trigger_d = 1'b0;
        yawns_d   = yawns_q + CountW'(1);
      end
    end
  end

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign pop_o     = (state_q == StIdle) & ~qstat_i.empty;

  // Sequencer over the per-frame steps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (!qstat_i.empty) state_d = StMag;
      StMag:   state_d = sat ? StWin : StDiv;
      StDiv:   if (div_cnt_q == '0) state_d = StWin;
      StWin:   state_d = (frames_q >= FramesW'(WindowSize)) ? StMed : StFin;
      StMed:   if (med_k_q == WinIdxW'(WindowSize - 1)) state_d = StFin;
      StFin:   if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      frames_q  <= '0;
      ready_q   <= 1'b0;
      trigger_q <= 1'b0;
      yawns_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StWin) begin
        ready_q <= (frames_q >= FramesW'(WindowSize));
        if (frames_q < FramesW'(WindowSize)) begin
          frames_q <= frames_q + FramesW'(1);
        end
      end
      if (state_q == StFin && slot_free) begin
        trigger_q <= trigger_d;
        yawns_q   <= yawns_d;
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        sum_q   <= head_i.sum;
        scale_q <= (head_i.scale == '0) ? ScaleW'(1) : head_i.scale;
      end
      StMag: begin
        if (sat) begin
          quot_q <= '1;
        end else begin
          rem_q     <= dvd_hi[ScaleW-1:0];
          quot_q    <= dividend[AreaW-1:0];
          div_cnt_q <= DivCntW'(AreaW - 1);
        end
      end
      StDiv: begin
        rem_q     <= trial_ge ? trial_diff[ScaleW-1:0] : trial[ScaleW-1:0];
        quot_q    <= {quot_q[AreaW-2:0], trial_ge};
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end
      StWin: begin
        for (int i = 0; i < WindowSize - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WindowSize-1] <= quot_q;
        med_k_q  <= '0;
        median_q <= '0;
      end
      StMed: begin
        if (rank == RankW'(MedianIdx)) begin
          median_q <= cand;
        end
        med_k_q <= med_k_q + WinIdxW'(1);
      end
      StFin: begin
        if (slot_free) begin
          out_norm_q    <= quot_q;
          out_median_q  <= median_q;
          out_ready_q   <= ready_q;
          out_yawning_q <= trigger_d;
          out_total_q   <= yawns_d;
        end
      end
      default: begin
        sum_q <= sum_q;
      end
    endcase
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StFin && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign normalized_area_o = out_norm_q;
  assign median_area_o     = out_median_q;
  assign window_ready_o    = out_ready_q;
  assign yawning_o         = out_yawning_q;
  assign yawn_total_o      = out_total_q;

endmodule

@@ design/yawn_detector_area_median.sv @@
// Yawn detector: one mouth-outline vertex per cycle in, one result word per frame out.
// A frame's word passes the product stage, the queue, the load, 24 divider steps and, with a
// full window, five median steps; a saturated frame skips the divider steps.
// Throughput: one vertex per cycle while the four-frame queue has room; the back end takes a
// new frame from the queue only once it has finished the last one.
// Reset: async, active low; queue emptied, counters and trigger cleared, threshold set to 250.0.
module yawn_detector_area_median
  import yda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] vertex_x_i,
  input  logic [CoordW-1:0] vertex_y_i,
  input  logic [ScaleW-1:0] frame_scale_i,
  input  logic              last_vertex_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [AreaW-1:0]  cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AreaW-1:0]  normalized_area_o,
  output logic [AreaW-1:0]  median_area_o,
  output logic              window_ready_o,
  output logic              yawning_o,
  output logic [CountW-1:0] yawn_total_o
);

  logic   push, pop;
  frame_t push_word, head;
  qstat_t qstat;

  // Vertex intake and shoelace accumulation.
  yda_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .frame_scale_i (frame_scale_i),
    .last_vertex_i (last_vertex_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .push_word_o   (push_word)
  );

  // Finished frames wait here for the back end.
  yda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // Division, median window and yawn counting.
  yda_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .qstat_i           (qstat),
    .head_i            (head),
    .pop_o             (pop),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .normalized_area_o (normalized_area_o),
    .median_area_o     (median_area_o),
    .window_ready_o    (window_ready_o),
    .yawning_o         (yawning_o),
    .yawn_total_o      (yawn_total_o)
  );

endmodule

@@ design/yda_checker.sv @@
// Port-level checker for the yawn detector, bound to the top level.
// Tracks the previous result word to check the yawn count and trigger history.
// Depends on yda_pkg.
module yda_checker
  import yda_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [AreaW-1:0]  normalized_area_o,
  input logic [AreaW-1:0]  median_area_o,
  input logic              window_ready_o,
  input logic              yawning_o,
  input logic [CountW-1:0] yawn_total_o
);

  logic              out_acc;
  logic              seen_word_q, seen_ready_q, prev_yawn_q;
  logic [CountW-1:0] prev_total_q;

  assign out_acc = out_valid_o & ~out_stall_i;

  // History of the last word taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_word_q  <= 1'b0;
      seen_ready_q <= 1'b0;
      prev_yawn_q  <= 1'b0;
      prev_total_q <= '0;
    end else if (out_acc) begin
      seen_word_q  <= 1'b1;
      seen_ready_q <= seen_ready_q | window_ready_o;
      prev_yawn_q  <= yawning_o;
      prev_total_q <= yawn_total_o;
    end
  end

  // A held word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(normalized_area_o)
      && $stable(median_area_o) && $stable(yawn_total_o))
    else $error("result word changed while stalled");

  // Before the window is full there is no median.
  a_no_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !window_ready_o |-> median_area_o == '0)
    else $error("median reported before the window was full");

  // Once the window has filled it stays full.
  a_ready_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_ready_q |-> window_ready_o)
    else $error("window_ready dropped after the window filled");

  // The count moves by one at most, and only on a falling trigger.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_word_q |-> (yawn_total_o == prev_total_q) ||
      ((yawn_total_o == prev_total_q + CountW'(1)) && prev_yawn_q && !yawning_o))
    else $error("yawn count stepped without a falling trigger");

  // Without a decision the trigger and count are left as they were.
  a_no_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_word_q && !window_ready_o |->
      (yawn_total_o == prev_total_q) && (yawning_o == prev_yawn_q))
    else $error("trigger or count changed without a decision");

endmodule

bind yawn_detector_area_median yda_checker u_yda_checker (.*);
